// ----- hdl/spr_pkg.sv -----
`default_nettype none

package spr_pkg;

   // request opcodes
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_WORD  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // response kinds
   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_ACK  = 1'b1;

   // acknowledgement codes
   localparam logic [1:0] ACK_STORED   = 2'd0;
   localparam logic [1:0] ACK_FULL     = 2'd1;
   localparam logic [1:0] ACK_TOO_LONG = 2'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] out_byte;
      logic       out_last;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic {
      S_IDLE,
      S_MATCH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic do_load;
      logic do_clear;
      logic word_read;
      logic word_skip;
      logic word_emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic match_done;
      logic out_blocked;
   } stat_type;

endpackage

`default_nettype wire

// ----- hdl/shortest_prefix_replacer_unit.sv -----
`default_nettype none

// Shortest-prefix word replacer.
// Input channel req_*: one word per byte, opcode load prefix byte, text byte
// or clear table; in_last flags the final byte of a prefix or text word.
// Output channel rsp_*: echoed text bytes (kind 0) and acknowledgements of a
// prefix's final byte or of a clear (kind 1, status = stored/full/too long).
// Both channels: a word moves when valid is high and stall is low.
// Acknowledgements are written straight into the output register when the
// request word is taken; text bytes first have the table row for the current
// position read from memory into a register before the parallel compare.
// Loads, clears and bytes after a match are taken one per cycle while req_stall
// is low; no new word is taken while a compared text byte is in the match step.
// Reset empties the table at once (prefix count to zero); table storage
// itself is not cleared and needs no sweep.
// When rsp_stall holds the output register, compared text bytes wait in the
// match step and acknowledging words are held off by req_stall; words that
// produce no result are still taken.
module shortest_prefix_replacer_unit #(
   parameter int NUM_PREFIXES   = 32,
   parameter int MAX_PREFIX_LEN = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  spr_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output spr_pkg::rsp_type rsp_data
);
   import spr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: accept, memory read, compare/emit
   spr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .stat      (stat),
      .cmd       (cmd)
   );

   // prefix table, match state and output register
   spr_datapath #(
      .NUM_PREFIXES   (NUM_PREFIXES),
      .MAX_PREFIX_LEN (MAX_PREFIX_LEN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- hdl/spr_ctrl.sv -----
`default_nettype none

module spr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spr_pkg::req_type  req_data,
   input  spr_pkg::stat_type stat,
   output spr_pkg::cmd_type  cmd
);
   import spr_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      needs_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      // these words answer at once, so the output register must be free
      needs_out = ((req_data.opcode == OP_LOAD) && req_data.in_last) ||
                  (req_data.opcode == OP_CLEAR);
      unique case (state_ff)
         S_IDLE: begin
            req_stall = needs_out && stat.out_blocked;
            if (req_valid && !req_stall) begin
               unique case (req_data.opcode)
                  OP_LOAD:  cmd.do_load  = 1'b1;
                  OP_CLEAR: cmd.do_clear = 1'b1;
                  OP_WORD: begin
                     if (stat.match_done) begin
                        cmd.word_skip = 1'b1;
                     end else begin
                        cmd.word_read = 1'b1;
                        state_in      = S_MATCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MATCH: begin
            req_stall = 1'b1;
            if (!stat.out_blocked) begin
               cmd.word_emit = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/spr_datapath.sv -----
`default_nettype none

module spr_datapath #(
   parameter int NUM_PREFIXES   = 32,
   parameter int MAX_PREFIX_LEN = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  spr_pkg::req_type  req_data,
   input  spr_pkg::cmd_type  cmd,
   output spr_pkg::stat_type stat,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output spr_pkg::rsp_type  rsp_data
);
   import spr_pkg::*;

   localparam int CNT_W    = $clog2(NUM_PREFIXES + 1);
   localparam int LANE_W   = (NUM_PREFIXES > 1) ? $clog2(NUM_PREFIXES) : 1;
   localparam int POS_W    = $clog2(MAX_PREFIX_LEN + 1);
   localparam int ROW_W    = (MAX_PREFIX_LEN > 1) ? $clog2(MAX_PREFIX_LEN) : 1;
   localparam int ROW_BITS = NUM_PREFIXES * 8;

   // one row per character position, one byte lane per prefix
   logic [ROW_BITS-1:0]     table_mem [MAX_PREFIX_LEN];
   logic [ROW_BITS-1:0]     row_ff;
   logic [POS_W-1:0]        len_ff [NUM_PREFIXES];
   logic [POS_W-1:0]        len_in;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [POS_W-1:0]        load_pos_ff, load_pos_in;
   logic                    too_long_ff, too_long_in;
   logic [POS_W-1:0]        word_pos_ff, word_pos_in;
   logic [NUM_PREFIXES-1:0] alive_ff, alive_in;
   logic                    match_done_ff, match_done_in;
   logic [7:0]              byte_ff;
   logic                    last_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic                    full;
   logic                    pos_ok;
   logic                    too_long_now;
   logic                    commit;
   logic                    mem_write;
   logic [LANE_W-1:0]       lane;
   logic [ROW_W-1:0]        wr_row;
   logic [ROW_W-1:0]        rd_row;
   logic                    p_in_range;
   logic [NUM_PREFIXES-1:0] hit_vec;
   logic [NUM_PREFIXES-1:0] kill_vec;
   logic                    hit;
   logic                    has_result;

   assign full         = (count_ff == CNT_W'(NUM_PREFIXES));
   assign pos_ok       = (load_pos_ff < POS_W'(MAX_PREFIX_LEN));
   assign too_long_now = too_long_ff || !pos_ok;
   assign lane         = count_ff[LANE_W-1:0];
   assign wr_row       = load_pos_ff[ROW_W-1:0];
   assign p_in_range   = (word_pos_ff < POS_W'(MAX_PREFIX_LEN));
   assign rd_row       = p_in_range ? word_pos_ff[ROW_W-1:0] : '0;
   assign mem_write    = cmd.do_load && !full && pos_ok;
   assign commit       = cmd.do_load && req_data.in_last && !full && !too_long_now;
   assign len_in       = load_pos_ff + POS_W'(1);
   assign has_result   = cmd.do_clear || (cmd.do_load && req_data.in_last) ||
                         cmd.word_emit;

   always_ff @(posedge clock) begin
      if (mem_write) begin
         table_mem[wr_row][lane*8 +: 8] <= req_data.in_byte;
      end
      if (cmd.word_read) begin
         row_ff  <= table_mem[rd_row];
         byte_ff <= req_data.in_byte;
         last_ff <= req_data.in_last;
      end
      if (commit) begin
         len_ff[lane] <= len_in;
      end
   end

   // parallel compare of every live prefix at the current position
   always_comb begin
      hit_vec  = '0;
      kill_vec = '0;
      for (int i = 0; i < NUM_PREFIXES; i++) begin
         if (alive_ff[i] && (CNT_W'(i) < count_ff)) begin
            if (!p_in_range || (word_pos_ff >= len_ff[i]) ||
                (row_ff[i*8 +: 8] != byte_ff)) begin
               kill_vec[i] = 1'b1;
            end else if ({1'b0, len_ff[i]} == ({1'b0, word_pos_ff} + (POS_W+1)'(1))) begin
               hit_vec[i] = 1'b1;
            end
         end
      end
      hit = |hit_vec;
   end

   always_comb begin
      count_in      = count_ff;
      load_pos_in   = load_pos_ff;
      too_long_in   = too_long_ff;
      word_pos_in   = word_pos_ff;
      alive_in      = alive_ff;
      match_done_in = match_done_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (has_result) begin
         rsp_valid_in = 1'b1;
      end

      if (cmd.do_clear) begin
         count_in      = '0;
         load_pos_in   = '0;
         too_long_in   = 1'b0;
         word_pos_in   = '0;
         alive_in      = '1;
         match_done_in = 1'b0;
         rsp_in        = '{kind: KIND_ACK, out_byte: 8'd0, out_last: 1'b0,
                           status: ACK_STORED};
      end

      if (cmd.do_load) begin
         if (pos_ok) begin
            load_pos_in = load_pos_ff + POS_W'(1);
         end else begin
            too_long_in = 1'b1;
         end
         if (req_data.in_last) begin
            rsp_in = '{kind: KIND_ACK, out_byte: 8'd0, out_last: 1'b0,
                       status: ACK_STORED};
            if (full) begin
               rsp_in.status = ACK_FULL;
            end else if (too_long_now) begin
               rsp_in.status = ACK_TOO_LONG;
            end else begin
               // a prefix landing mid text word joins from the next one
               alive_in[lane] = (word_pos_ff == '0) && !match_done_ff;
               count_in       = count_ff + CNT_W'(1);
            end
            load_pos_in = '0;
            too_long_in = 1'b0;
         end
      end

      if (cmd.word_skip && req_data.in_last) begin
         word_pos_in   = '0;
         alive_in      = '1;
         match_done_in = 1'b0;
      end

      if (cmd.word_emit) begin
         rsp_in = '{kind: KIND_TEXT, out_byte: byte_ff, out_last: hit || last_ff,
                    status: ACK_STORED};
         if (last_ff) begin
            word_pos_in   = '0;
            alive_in      = '1;
            match_done_in = 1'b0;
         end else begin
            alive_in      = alive_ff & ~kill_vec;
            match_done_in = hit;
            if (p_in_range) begin
               word_pos_in = word_pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         load_pos_ff   <= '0;
         too_long_ff   <= 1'b0;
         word_pos_ff   <= '0;
         alive_ff      <= '1;
         match_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         load_pos_ff   <= load_pos_in;
         too_long_ff   <= too_long_in;
         word_pos_ff   <= word_pos_in;
         alive_ff      <= alive_in;
         match_done_ff <= match_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;
   assign stat.match_done  = match_done_ff;
   assign stat.out_blocked = rsp_valid_ff && rsp_stall;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NUM_PREFIXES))
      else $error("prefix count beyond table size");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.word_emit || cmd.do_clear) |-> !(rsp_valid_ff && rsp_stall))
      else $error("result written over a stalled response");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.do_clear |=> (count_ff == '0) && (word_pos_ff == '0))
      else $error("clear did not empty the table");

   a_done_pos: assert property (@(posedge clock) disable iff (reset)
      match_done_ff |-> (word_pos_ff != '0))
      else $error("match done at text word start");

endmodule

`default_nettype wire
